@@ src/irclt_pkg.sv @@
// types and constants shared by the irc line tokenizer
`default_nettype none

package irclt_pkg;

    // parser modes
    typedef enum logic [3:0] {
        M_LINE_START = 4'd0,
        M_PFX_SKIP   = 4'd1,
        M_PFX_TEXT   = 4'd2,
        M_CMD_SKIP   = 4'd3,
        M_CMD_TEXT   = 4'd4,
        M_ARG_START  = 4'd5,
        M_ARG_TEXT   = 4'd6,
        M_TRAIL      = 4'd7
    } t_mode;

    // field kind codes
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_PREFIX   = 3'd1;
    localparam logic [2:0] KIND_COMMAND  = 3'd2;
    localparam logic [2:0] KIND_MIDDLE   = 3'd3;
    localparam logic [2:0] KIND_TRAILING = 3'd4;

    // marker byte for prefix and trailing parameter
    localparam logic [7:0] COLON_BYTE = 8'h3A;

    // input request
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } t_in;

    // result request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [2:0] field_kind;
        logic [3:0] param_number;
        logic       field_end;
        logic       line_end;
        logic       param_overflow;
    } t_out;

    // whitespace is tab to carriage return and space
    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

@@ src/irc_line_tokenizer_top.sv @@
// irc line tokenizer: labels each byte of an irc message line
//
// Input channel: one line byte per request with a flag on the final byte
// (i_in_valid, o_in_stall, i_in_data). Output channel: one labelled byte per
// request (o_out_valid, i_out_stall, o_out_data) carrying the byte, whether
// it is field text, the field kind, parameter index, field end, line end and
// a sticky parameter overflow flag for the line.
// The label is computed from the byte and the parser state and held in the
// output register. One byte per cycle is accepted while o_in_stall is low;
// the parser state takes a single mode/count update per byte.
// A byte is taken while the output register is empty or is being emptied in
// the same cycle, so when the receiver stalls with a result held, o_in_stall
// rises and the held result does not change.
// Reset puts the parser at line start with parameter count and overflow
// cleared and empties the output register. The final byte of a line returns
// the parser to that same state.
`default_nettype none

module irc_line_tokenizer_top #(
    parameter int MAX_PARAMS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  irclt_pkg::t_in    i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output irclt_pkg::t_out   o_out_data
);
    import irclt_pkg::*;

    // highest parameter index the count reaches
    localparam int CAP_INT = (MAX_PARAMS > 16) ? 15 : (MAX_PARAMS - 1);
    localparam logic [3:0] PARAM_CAP = CAP_INT[3:0];

    t_mode      r_mode, n_mode;
    logic [3:0] r_count, n_count;
    logic       r_ovf, n_ovf;
    logic       r_out_valid;
    t_out       r_out, n_out;

    logic       accept;
    logic       ws;
    logic       colon;
    t_mode      eff_mode;
    t_mode      next_mode;
    logic [2:0] kind;
    logic       dv;
    logic       fe;
    logic       is_param;

    // handshake
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign ws    = is_blank(i_in_data.line_byte);
    assign colon = (i_in_data.line_byte == COLON_BYTE);

    // byte labelling and next mode
    always_comb begin
        kind      = KIND_NONE;
        dv        = 1'b0;
        fe        = 1'b0;
        next_mode = r_mode;
        eff_mode  = r_mode;
        // unused codes behave as line start
        if (r_mode > M_TRAIL) begin
            eff_mode  = M_LINE_START;
        end
        if ((eff_mode == M_LINE_START) && !colon) begin
            eff_mode  = M_CMD_SKIP;
        end
        unique case (eff_mode)
            M_LINE_START: begin
                kind      = KIND_PREFIX;
                next_mode = M_PFX_SKIP;
            end
            M_PFX_SKIP, M_PFX_TEXT: begin
                kind      = KIND_PREFIX;
                next_mode = eff_mode;
                if (!ws) begin
                    dv        = 1'b1;
                    next_mode = M_PFX_TEXT;
                end else if (eff_mode == M_PFX_TEXT) begin
                    fe        = 1'b1;
                    next_mode = M_CMD_SKIP;
                end
            end
            M_CMD_SKIP, M_CMD_TEXT: begin
                kind      = KIND_COMMAND;
                next_mode = eff_mode;
                if (!ws) begin
                    dv        = 1'b1;
                    next_mode = M_CMD_TEXT;
                end else if (eff_mode == M_CMD_TEXT) begin
                    fe        = 1'b1;
                    next_mode = M_ARG_START;
                end
            end
            M_ARG_START: begin
                if (colon) begin
                    kind      = KIND_TRAILING;
                    next_mode = M_TRAIL;
                end else if (ws) begin
                    kind      = KIND_MIDDLE;
                    fe        = 1'b1;
                    next_mode = M_ARG_START;
                end else begin
                    kind      = KIND_MIDDLE;
                    dv        = 1'b1;
                    next_mode = M_ARG_TEXT;
                end
            end
            M_ARG_TEXT: begin
                kind      = KIND_MIDDLE;
                next_mode = M_ARG_TEXT;
                if (ws) begin
                    fe        = 1'b1;
                    next_mode = M_ARG_START;
                end else begin
                    dv        = 1'b1;
                end
            end
            M_TRAIL: begin
                kind      = KIND_TRAILING;
                dv        = 1'b1;
                next_mode = M_TRAIL;
            end
            default: begin
                // unused codes are folded into line start above
                kind      = KIND_NONE;
                next_mode = M_LINE_START;
            end
        endcase
        if (i_in_data.line_last) begin
            fe = 1'b1;
        end
    end

    // parameter count, overflow and result word
    assign is_param = (kind == KIND_MIDDLE) || (kind == KIND_TRAILING);

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (fe && is_param) begin
            if (r_count < PARAM_CAP) begin
                n_count = r_count + 4'd1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        n_out.data_byte      = i_in_data.line_byte;
        n_out.data_valid     = dv;
        n_out.field_kind     = kind;
        n_out.param_number   = is_param ? r_count : 4'd0;
        n_out.field_end      = fe;
        n_out.line_end       = i_in_data.line_last;
        n_out.param_overflow = n_ovf;
        n_mode               = next_mode;
        if (i_in_data.line_last) begin
            n_mode  = M_LINE_START;
            n_count = 4'd0;
            n_ovf   = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_LINE_START;
            r_count <= 4'd0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the irc line tokenizer: directed and random lines
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import irclt_pkg::*;

    localparam int PARAM_LIMIT = 16;
    localparam logic [3:0] PARAM_CAP = (PARAM_LIMIT > 16) ? 4'd15 : 4'(PARAM_LIMIT - 1);
    localparam int RANDOM_ITEMS = 1300;

    // expected labels for accepted line bytes, with the parser state mirrored here
    class line_label_tracker;
        t_mode      mode_now;
        logic [3:0] param_index;
        logic       overflow_flag;
        t_out       pending_labels[$];
        int         fail_count;

        function new();
            restart();
            fail_count = 0;
        endfunction

        function void restart();
            mode_now = M_LINE_START;
            param_index = '0;
            overflow_flag = 1'b0;
        endfunction

        static function logic is_gap(logic [7:0] b);
            return b inside {8'h20, [8'h09:8'h0D]};
        endfunction

        // label one byte and advance the mirrored parser
        function t_out label_byte(t_in req);
            t_out  lab;
            t_mode step_mode;
            t_mode nxt;
            logic  ws;
            logic  taken;
            step_mode = mode_now;
            nxt = mode_now;
            ws = is_gap(req.line_byte);
            taken = 1'b0;
            lab = '0;
            lab.data_byte = req.line_byte;
            lab.field_kind = KIND_NONE;

            // a colon opening the line marks a prefix, anything else starts the command
            if (step_mode == M_LINE_START) begin
                if (req.line_byte == COLON_BYTE) begin
                    lab.field_kind = KIND_PREFIX;
                    nxt = M_PFX_SKIP;
                    taken = 1'b1;
                end else begin
                    step_mode = M_CMD_SKIP;
                end
            end

            if (!taken) begin
                nxt = step_mode;
                case (step_mode)
                    M_PFX_SKIP, M_PFX_TEXT: begin
                        lab.field_kind = KIND_PREFIX;
                        if (!ws) begin
                            lab.data_valid = 1'b1;
                            nxt = M_PFX_TEXT;
                        end else if (step_mode == M_PFX_TEXT) begin
                            lab.field_end = 1'b1;
                            nxt = M_CMD_SKIP;
                        end
                    end
                    M_CMD_SKIP, M_CMD_TEXT: begin
                        lab.field_kind = KIND_COMMAND;
                        if (!ws) begin
                            lab.data_valid = 1'b1;
                            nxt = M_CMD_TEXT;
                        end else if (step_mode == M_CMD_TEXT) begin
                            lab.field_end = 1'b1;
                            nxt = M_ARG_START;
                        end
                    end
                    M_ARG_START: begin
                        if (req.line_byte == COLON_BYTE) begin
                            lab.field_kind = KIND_TRAILING;
                            nxt = M_TRAIL;
                        end else if (ws) begin
                            // blank where a parameter would start: empty parameter
                            lab.field_kind = KIND_MIDDLE;
                            lab.field_end = 1'b1;
                        end else begin
                            lab.field_kind = KIND_MIDDLE;
                            lab.data_valid = 1'b1;
                            nxt = M_ARG_TEXT;
                        end
                    end
                    M_ARG_TEXT: begin
                        lab.field_kind = KIND_MIDDLE;
                        if (ws) begin
                            lab.field_end = 1'b1;
                            nxt = M_ARG_START;
                        end else begin
                            lab.data_valid = 1'b1;
                        end
                    end
                    default: begin
                        lab.field_kind = KIND_TRAILING;
                        lab.data_valid = 1'b1;
                    end
                endcase
            end

            if (lab.field_kind >= KIND_MIDDLE) lab.param_number = param_index;
            if (req.line_last) lab.field_end = 1'b1;
            lab.line_end = req.line_last;

            // parameter index saturates at the cap and flags overflow
            if (lab.field_end && lab.field_kind >= KIND_MIDDLE) begin
                if (param_index < PARAM_CAP) param_index = param_index + 4'd1;
                else overflow_flag = 1'b1;
            end
            lab.param_overflow = overflow_flag;

            if (req.line_last) restart();
            else mode_now = nxt;
            return lab;
        endfunction

        function void note_byte(t_in req);
            pending_labels.insert(pending_labels.size(), label_byte(req));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_label(t_out got);
            t_out want;
            if (pending_labels.size() == 0) begin
                $error("result with no byte outstanding: 0x%0h", got);
                fail_count++;
                return;
            end
            want = pending_labels.pop_front();
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("data_valid", want.data_valid, got.data_valid);
            compare_field("field_kind", want.field_kind, got.field_kind);
            compare_field("param_number", want.param_number, got.param_number);
            compare_field("field_end", want.field_end, got.field_end);
            compare_field("line_end", want.line_end, got.line_end);
            compare_field("param_overflow", want.param_overflow, got.param_overflow);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    t_in  i_in_data = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    line_label_tracker tracker = new();
    logic [7:0] line_bytes[$];
    bit   send_steady = 1'b0;
    int   random_sent = 0;

    irc_line_tokenizer_top #(
        .MAX_PARAMS(PARAM_LIMIT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // offer one byte request, optionally after an idle gap, and wait until taken
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= '{line_byte: b, line_last: last};
        forever begin
            @(posedge i_clk);
            if (i_in_valid && o_in_stall === 1'b0) break;
        end
        tracker.note_byte(i_in_data);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_queued_line();
        send_steady = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < line_bytes.size(); i++) begin
            send_byte(line_bytes[i], i == line_bytes.size() - 1);
            random_sent++;
        end
    endtask

    // add one byte to the end of the line being built
    function automatic void add_line_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    function automatic logic [7:0] pick_blank();
        int v;
        v = $urandom_range(7, 13);
        return (v <= 8) ? 8'h20 : 8'(v);
    endfunction

    // non-blank byte, colons made common
    function automatic logic [7:0] pick_solid();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0) return COLON_BYTE;
        do b = 8'($urandom_range(0, 255)); while (line_label_tracker::is_gap(b));
        return b;
    endfunction

    // mostly well-formed lines with random content, some raw noise
    function automatic void build_line();
        int nparams;
        line_bytes.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 3))
                    0: add_line_byte(pick_blank());
                    1: add_line_byte(COLON_BYTE);
                    default: add_line_byte(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        if ($urandom_range(0, 1)) begin
            add_line_byte(COLON_BYTE);
            repeat ($urandom_range(0, 1)) add_line_byte(pick_blank());
            repeat ($urandom_range(1, 6)) add_line_byte(pick_solid());
            add_line_byte(pick_blank());
        end
        repeat ($urandom_range(0, 1)) add_line_byte(pick_blank());
        repeat ($urandom_range(1, 6)) add_line_byte(pick_solid());
        nparams = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
        repeat (nparams) begin
            add_line_byte(pick_blank());
            repeat ($urandom_range(0, 4)) add_line_byte(pick_solid());
        end
        if ($urandom_range(0, 1)) begin
            add_line_byte(pick_blank());
            add_line_byte(COLON_BYTE);
            repeat ($urandom_range(0, 6)) add_line_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // result side: random stalls, with calm stretches, then take one result
    initial begin
        int gap;
        int run_left;
        bit steady;
        steady = 1'b0;
        run_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (run_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(10, 60);
            end
            run_left--;
            gap = steady ? 0 : $urandom_range(0, 10);
            repeat (gap) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            forever begin
                @(posedge i_clk);
                if (o_out_valid === 1'b1) break;
            end
            tracker.check_label(o_out_data);
        end
    end

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // lone prefix colon and lone blank, both closing empty fields at line end
        send_text(":");
        send_text(" ");
        // prefix, tab separator, colon inside a middle parameter, trailing
        send_text(":p\tc x:y :t");
        // high bytes as command text, carriage return separator, nul parameter
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'h00, 1'b1);
        // double space gives an empty parameter, then a lone trailing colon
        send_text("c  :");
        // blank as the last byte closes an empty parameter
        send_text("c a  ");

        while (random_sent < RANDOM_ITEMS) begin
            build_line();
            send_queued_line();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (tracker.pending_labels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tracker.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ irc_line_tokenizer_top.f @@
src/irclt_pkg.sv
src/irc_line_tokenizer_top.sv
verif/testbench.sv
